FILE: rtl/core/m4vt_pkg.sv
// Package with the request, response and lane result types of the matrix-vector transform.
package m4vt_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned DIM    = 4;

  // Request type codes.
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_VECTOR = 2'd1;
  localparam logic [1:0] REQ_POINT  = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [1:0]                column;
    logic signed [DATA_W-1:0]  in_x;
    logic signed [DATA_W-1:0]  in_y;
    logic signed [DATA_W-1:0]  in_z;
    logic signed [DATA_W-1:0]  in_w;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  out_x;
    logic signed [DATA_W-1:0]  out_y;
    logic signed [DATA_W-1:0]  out_z;
    logic signed [DATA_W-1:0]  out_w;
    logic                      saturated;
  } resp_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic signed [DATA_W-1:0]  dot;
    logic                      sat;
  } lane_res_t;

endpackage

FILE: rtl/core/m4vt_stream_if.sv
// Valid/ready stream interface carrying one payload of a chosen type.
interface m4vt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/mat4_vector_transform.sv
// Top level of the 4x4 fixed-point matrix times vector transform.
//
//   Channel   Role    Payload   Transfers
//   req       sink    req_t     load column, transform vector or transform point
//   resp      source  resp_t    one response per transform request
//
// Throughput is one request per clock while resp is not stalled. A transform request passes
// through the product registers into the response register: the sixteen multipliers
// (four per lane) fill the product registers at the transfer, and the lane sums, shift
// and saturation then fill the response register.
// Reset loads the identity matrix and empties the pipeline.
// A stalled response holds in the output register while the product stage still
// takes a request; req.ready drops only when both stages are occupied.
// A load takes effect for a transform that transfers on the very next clock.
module mat4_vector_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  m4vt_stream_if.sink                            req,
  m4vt_stream_if.source                          resp
);

  localparam logic signed [m4vt_pkg::DATA_W-1:0] ONE =
    m4vt_pkg::DATA_W'(1) << FRAC_BITS;

  // Column-major store: entry (row r, column c) sits at mat[c*4 + r].
  logic [m4vt_pkg::DATA_W-1:0] mat [m4vt_pkg::DIM * m4vt_pkg::DIM];

  logic s1_valid;
  logic s1_point;
  logic out_valid;

  logic out_free;
  logic s1_free;
  logic accept;
  logic is_load;
  logic is_xform;
  logic is_point;

  logic [m4vt_pkg::DIM-1:0][m4vt_pkg::DATA_W-1:0] vec;
  logic [m4vt_pkg::DIM-1:0][m4vt_pkg::DIM-1:0][m4vt_pkg::DATA_W-1:0] rows;
  m4vt_pkg::lane_res_t [m4vt_pkg::DIM-1:0] lane_res;

  // The output register frees when it is empty or its transfer completes;
  // the product stage advances whenever the output register can take it.
  assign out_free = !out_valid || resp.ready;
  assign s1_free  = !s1_valid || out_free;
  assign req.ready = s1_free;
  assign accept    = req.valid && s1_free;

  assign is_load  = req.data.req_type == m4vt_pkg::REQ_LOAD;
  assign is_point = req.data.req_type == m4vt_pkg::REQ_POINT;
  assign is_xform = is_point || (req.data.req_type == m4vt_pkg::REQ_VECTOR);

  // Point mode substitutes w = 1.0 in the current fixed-point format.
  assign vec[0] = req.data.in_x;
  assign vec[1] = req.data.in_y;
  assign vec[2] = req.data.in_z;
  assign vec[3] = is_point ? ONE : req.data.in_w;

  always_comb begin
    for (int r = 0; r < m4vt_pkg::DIM; r++) begin
      for (int c = 0; c < m4vt_pkg::DIM; c++) begin
        rows[r][c] = mat[c * m4vt_pkg::DIM + r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < m4vt_pkg::DIM * m4vt_pkg::DIM; i++) begin
        mat[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else if (accept && is_load) begin
      for (int c = 0; c < m4vt_pkg::DIM; c++) begin
        if (req.data.column == 2'(c)) begin
          for (int r = 0; r < m4vt_pkg::DIM; r++) begin
            mat[c * m4vt_pkg::DIM + r] <= vec[r];
          end
        end
      end
    end
  end

  // Pipeline control. Unused request codes transfer and are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_point  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= accept && is_xform;
        s1_point <= is_point;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  for (genvar r = 0; r < m4vt_pkg::DIM; r++) begin : g_lane
    m4vt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .en  (s1_free),
      .row (rows[r]),
      .vec (vec),
      .res (lane_res[r])
    );
  end

  m4vt_merge u_merge (
    .clk   (clk),
    .en    (out_free && s1_valid),
    .point (s1_point),
    .lanes (lane_res),
    .resp  (resp.data)
  );

  assign resp.valid = out_valid;

endmodule

FILE: rtl/core/m4vt_lane.sv
// One row lane: four registered products, then an exact sum, floor shift and saturation.
module m4vt_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                                 clk,
  input  logic                                                 en,
  input  logic [m4vt_pkg::DIM-1:0][m4vt_pkg::DATA_W-1:0]       row,
  input  logic [m4vt_pkg::DIM-1:0][m4vt_pkg::DATA_W-1:0]       vec,
  output m4vt_pkg::lane_res_t                                  res
);

  localparam int unsigned PROD_W = 2 * m4vt_pkg::DATA_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] MAX_V = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] MIN_V = -(SUM_W'(64'sd2147483648));

  logic signed [PROD_W-1:0] prod [m4vt_pkg::DIM];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < m4vt_pkg::DIM; c++) begin
        prod[c] <= $signed(row[c]) * $signed(vec[c]);
      end
    end
  end

  // The sum is exact; the arithmetic shift rounds toward minus infinity.
  assign sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
  assign shifted = sum >>> FRAC_BITS;

  always_comb begin
    if (shifted > MAX_V) begin
      res.dot = 32'sh7FFF_FFFF;
      res.sat = 1'b1;
    end else if (shifted < MIN_V) begin
      res.dot = 32'sh8000_0000;
      res.sat = 1'b1;
    end else begin
      res.dot = shifted[m4vt_pkg::DATA_W-1:0];
      res.sat = 1'b0;
    end
  end

endmodule

FILE: rtl/core/m4vt_merge.sv
// Merge stage: gathers the four lane results into the registered response.
module m4vt_merge (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   point,
  input  m4vt_pkg::lane_res_t [m4vt_pkg::DIM-1:0] lanes,
  output m4vt_pkg::resp_t                        resp
);

  m4vt_pkg::resp_t resp_next;

  always_comb begin
    resp_next.out_x = lanes[0].dot;
    resp_next.out_y = lanes[1].dot;
    resp_next.out_z = lanes[2].dot;
    // In point mode the fourth row carries no meaning and does not flag.
    if (point) begin
      resp_next.out_w     = '0;
      resp_next.saturated = lanes[0].sat | lanes[1].sat | lanes[2].sat;
    end else begin
      resp_next.out_w     = lanes[3].dot;
      resp_next.saturated = lanes[0].sat | lanes[1].sat | lanes[2].sat | lanes[3].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      resp <= resp_next;
    end
  end

endmodule
